// File: src/scd_pkg.sv
// shared types, constants and lookup tables of the set 1 scan code decoder
package scd_pkg;

   localparam int MAP_ENTRIES = 128;
   localparam int MAP_IDX_W   = $clog2(MAP_ENTRIES);
   localparam int FLAG_W      = 7;
   localparam int LED_W       = 3;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_PRESS = 2'd1;
   localparam logic [1:0] KIND_SEND  = 2'd2;

   localparam logic [7:0] SC_E0       = 8'hE0;
   localparam logic [7:0] SC_E1       = 8'hE1;
   localparam logic [7:0] SC_PAUSE_1  = 8'h1D;
   localparam logic [7:0] SC_PAUSE_2  = 8'h45;
   localparam logic [7:0] SC_LSHIFT   = 8'h2A;
   localparam logic [7:0] SC_RSHIFT   = 8'h36;
   localparam logic [7:0] SC_ERROR    = 8'hFF;
   localparam logic [7:0] SC_ACK      = 8'hFA;
   localparam logic [7:0] SC_RESEND   = 8'hFE;
   localparam logic [7:0] SC_NULL     = 8'h00;
   localparam logic [7:0] SC_E0_LIMIT = 8'd96;
   localparam logic [7:0] PAUSE_CODE  = 8'd119;

   localparam logic [7:0] CMD_ENABLE  = 8'hF4;
   localparam logic [7:0] CMD_SET_LED = 8'hED;

   // keymap: character in the low byte, modifier bits in the high byte
   localparam logic [15:0] KEYMAP [MAP_ENTRIES] = '{
      16'h0000, 16'h001B, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036,
      16'h0037, 16'h0038, 16'h0039, 16'h0030, 16'h002D, 16'h005E, 16'h0008, 16'h0009,
      16'h0071, 16'h0077, 16'h0065, 16'h0072, 16'h0074, 16'h0079, 16'h0075, 16'h0069,
      16'h006F, 16'h0070, 16'h005B, 16'h005D, 16'h000A, 16'h0800, 16'h0061, 16'h0073,
      16'h0064, 16'h0066, 16'h0067, 16'h0068, 16'h006A, 16'h006B, 16'h006C, 16'h003B,
      16'h0027, 16'h0060, 16'h1000, 16'h005C, 16'h007A, 16'h0078, 16'h0063, 16'h0076,
      16'h0062, 16'h006E, 16'h006D, 16'h002C, 16'h002E, 16'h002F, 16'h1000, 16'h002A,
      16'h0200, 16'h0020, 16'h2000, 16'h0080, 16'h0081, 16'h0082, 16'h0083, 16'h0084,
      16'h0085, 16'h0086, 16'h0087, 16'h0088, 16'h0089, 16'h4000, 16'h8000, 16'h0037,
      16'h0038, 16'h0039, 16'h002D, 16'h0034, 16'h0035, 16'h0036, 16'h002B, 16'h0031,
      16'h0032, 16'h0033, 16'h0030, 16'h002E, 16'h0000, 16'h0000, 16'h0000, 16'h008A,
      16'h008B, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h000A, 16'h0800, 16'h002F, 16'h009A, 16'h0400, 16'h0000, 16'h0092,
      16'h0097, 16'h0094, 16'h0096, 16'h0099, 16'h0093, 16'h0098, 16'h0095, 16'h0090,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
   };

   // remap of extended codes, zero where no entry exists
   function automatic logic [7:0] e0_remap(input logic [MAP_IDX_W-1:0] idx);
      logic [7:0] res;
      case (idx)
         7'h1C: res = 8'd97;
         7'h1D: res = 8'd98;
         7'h35: res = 8'd99;
         7'h37: res = 8'd100;
         7'h38: res = 8'd101;
         7'h47: res = 8'd103;
         7'h48: res = 8'd104;
         7'h49: res = 8'd105;
         7'h4B: res = 8'd106;
         7'h4D: res = 8'd107;
         7'h4F: res = 8'd108;
         7'h50: res = 8'd109;
         7'h51: res = 8'd110;
         7'h52: res = 8'd111;
         default: res = 8'd0;
      endcase
      return res;
   endfunction

   typedef struct packed {
      logic                 led_change;
      logic [LED_W-1:0]     leds;
      logic                 press;
      logic [MAP_IDX_W-1:0] code;
      logic [15:0]          key_value;
      logic [FLAG_W-1:0]    flags;
   } scd_item_type;

endpackage

// File: src/scd_front.sv
// front end: prefix tracking, filtering, modifier and led state, item classification
module scd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [7:0]           req_scancode,
   output logic                 req_stall,
   input  logic                 queue_full,
   output logic                 push,
   output scd_pkg::scd_item_type item
);
   import scd_pkg::*;

   typedef enum logic [1:0] {
      PFX_NONE,
      PFX_E0,
      PFX_E1,
      PFX_E1_1D
   } prefix_type;

   prefix_type        prefix_ff, prefix_in;
   logic [FLAG_W-1:0] mod_ff, mod_in;
   logic [LED_W-1:0]  led_ff, leds_new;
   logic [7:0]        code;
   logic              drop;
   logic [15:0]       key;
   logic [FLAG_W-1:0] key_bit;
   logic              is_lock;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      drop      = 1'b0;
      prefix_in = PFX_NONE;
      code      = req_scancode;
      case (prefix_ff)
         PFX_E0: begin
            if (req_scancode == SC_LSHIFT || req_scancode == SC_RSHIFT ||
                req_scancode >= SC_E0_LIMIT) begin
               drop = 1'b1;
            end else begin
               code = e0_remap(req_scancode[MAP_IDX_W-1:0]);
            end
         end
         PFX_E1: begin
            if (req_scancode == SC_PAUSE_1) begin
               drop      = 1'b1;
               prefix_in = PFX_E1_1D;
            end
         end
         PFX_E1_1D: begin
            if (req_scancode == SC_PAUSE_2) begin
               code = PAUSE_CODE;
            end
         end
         default: begin
         end
      endcase
      if (!drop) begin
         if (code == SC_ERROR || code == SC_ACK || code == SC_RESEND || code == SC_NULL) begin
            drop = 1'b1;
         end else if (code == SC_E0) begin
            drop      = 1'b1;
            prefix_in = PFX_E0;
         end else if (code == SC_E1) begin
            drop      = 1'b1;
            prefix_in = PFX_E1;
         end
      end

      key     = KEYMAP[code[MAP_IDX_W-1:0]];
      key_bit = key[15:9];
      is_lock = |key[15:13];

      mod_in = mod_ff;
      if (!drop && key[7:0] == 8'd0) begin
         if (code[7]) begin
            if (!is_lock) begin
               mod_in = mod_ff & ~key_bit;
            end
         end else if (is_lock) begin
            mod_in = mod_ff ^ key_bit;
         end else begin
            mod_in = mod_ff | key_bit;
         end
      end

      // led byte: bit2 caps, bit1 num, bit0 scroll
      leds_new = {mod_in[4], mod_in[5], mod_in[6]};

      item.led_change = !drop && (leds_new != led_ff);
      item.leds       = leds_new;
      item.press      = !drop && !code[7];
      item.code       = code[MAP_IDX_W-1:0];
      item.key_value  = key;
      item.flags      = mod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= PFX_NONE;
         mod_ff    <= '0;
         led_ff    <= '0;
      end else if (push) begin
         prefix_ff <= prefix_in;
         mod_ff    <= mod_in;
         led_ff    <= leds_new;
      end
   end

endmodule

// File: src/scd_queue.sv
// short fifo of classified items between front and back
module scd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  scd_pkg::scd_item_type push_item,
   input  logic                  pop,
   output logic                  full,
   output logic                  head_valid,
   output scd_pkg::scd_item_type head_item
);
   import scd_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   scd_item_type  slot_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: src/scd_back.sv
// back end: expands each item into its result beats through an output register
module scd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  scd_pkg::scd_item_type head_item,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_data_byte,
   output logic [15:0]           rsp_key_value,
   output logic [6:0]            rsp_modifier_flags,
   output logic                  rsp_last
);
   import scd_pkg::*;

   logic [1:0]        step_ff;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_kind_ff;
   logic [7:0]        rsp_data_byte_ff;
   logic [15:0]       rsp_key_value_ff;
   logic [FLAG_W-1:0] rsp_flags_ff;
   logic              rsp_last_ff;

   logic              load;
   logic [1:0]        kind_in;
   logic [7:0]        data_in;
   logic [15:0]       key_in;
   logic              last_in;

   assign load = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = load && last_in;

   always_comb begin
      kind_in = KIND_PRESS;
      data_in = {1'b0, head_item.code};
      key_in  = head_item.key_value;
      last_in = 1'b1;
      if (head_item.led_change) begin
         case (step_ff)
            2'd0: begin
               kind_in = KIND_SEND;
               data_in = CMD_ENABLE;
               key_in  = '0;
               last_in = 1'b0;
            end
            2'd1: begin
               kind_in = KIND_SEND;
               data_in = CMD_SET_LED;
               key_in  = '0;
               last_in = 1'b0;
            end
            2'd2: begin
               kind_in = KIND_SEND;
               data_in = {5'd0, head_item.leds};
               key_in  = '0;
               last_in = !head_item.press;
            end
            default: begin
            end
         endcase
      end else if (!head_item.press) begin
         kind_in = KIND_NONE;
         data_in = '0;
         key_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            step_ff      <= last_in ? 2'd0 : step_ff + 2'd1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_kind_ff      <= kind_in;
         rsp_data_byte_ff <= data_in;
         rsp_key_value_ff <= key_in;
         rsp_flags_ff     <= head_item.flags;
         rsp_last_ff      <= last_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_data_byte      = rsp_data_byte_ff;
   assign rsp_key_value      = rsp_key_value_ff;
   assign rsp_modifier_flags = rsp_flags_ff;
   assign rsp_last           = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_step_advance: assert property (@(posedge clock) disable iff (reset)
      load && !last_in |=> step_ff == 2'($past(step_ff) + 2'd1))
      else $error("step counter did not advance");
   a_mid_item_head: assert property (@(posedge clock) disable iff (reset)
      step_ff != 2'd0 |-> head_valid)
      else $error("queue head lost in the middle of an item");
   a_fourth_beat: assert property (@(posedge clock) disable iff (reset)
      step_ff == 2'd3 |-> head_item.led_change && head_item.press)
      else $error("fourth beat without led update and press");
   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_NONE |-> rsp_last_ff)
      else $error("empty result not marked last");
`endif

endmodule

// File: src/ps2_set1_scancode_decoder.sv
// top level of the set 1 scan code decoder
// first result beat of a byte: through the item queue, then the output register
// throughput: one input beat per cycle while the item queue has room; the output
//   register gives one result beat per cycle unless rsp_stall holds it, 1 to 4
//   beats per byte, so the back end sets the sustained rate
// reset: synchronous; clears prefix, modifier and led state, the queue and the output
module ps2_set1_scancode_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_scancode,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [15:0] rsp_key_value,
   output logic [6:0]  rsp_modifier_flags,
   output logic        rsp_last
);
   import scd_pkg::*;

   scd_item_type push_item, head_item;
   logic         push, pop, queue_full, head_valid;

   scd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_scancode (req_scancode),
      .req_stall    (req_stall),
      .queue_full   (queue_full),
      .push         (push),
      .item         (push_item)
   );

   scd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   scd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_item          (head_item),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_key_value      (rsp_key_value),
      .rsp_modifier_flags (rsp_modifier_flags),
      .rsp_last           (rsp_last)
   );

endmodule
